>>> src/vnacc_pkg.sv
// Vertex normal accumulator package: widths, item kind codes, FSM state type.
// No dependencies; imported by vertex_normal_accumulator_unit.
`default_nettype none
package vnacc_pkg;
    localparam int DEF_VERTEX_DEPTH = 4096;
    localparam int DEF_COORD_BITS   = 16;
    localparam int VTX_W            = 12;
    localparam int ACC_W            = 24;
    localparam int UNIT_W           = 16;
    localparam int NORM_W           = 30;
    localparam int LEN_W            = 31;
    localparam int SQR_W            = 62;
    localparam int QUO_W            = 17;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_LOAD = 2'd0;
    localparam kind_t KIND_TRI  = 2'd1;
    localparam kind_t KIND_READ = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_OUT,
        ST_POS,
        ST_EDGE,
        ST_CROSS,
        ST_MAG,
        ST_MAX,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_ACC_RD,
        ST_ACC_WR
    } state_t;
endpackage
`default_nettype wire

>>> src/vertex_normal_accumulator_unit.sv
// Vertex normal accumulator top level: position and normal stores, face normal datapath.
// Depends on vnacc_pkg and vnacc_ram.
//
//  channel | signals                                           | dir
//  s_      | s_valid s_ready s_kind s_vertex_a/b/c s_pos_x/y/z | in
//  m_      | m_valid m_ready m_normal_x/y/z                    | out
//
// Load: written while the unit stays idle. Read: waits for the output register to drain.
// Triangle: ends early for a degenerate one, else its time is set by the
// one-bit-per-cycle normalizing shift, a 31-step square root and three 17-step
// restoring divisions.
// After reset the normal store is zeroed with s_ready low.
// A finished read item waits in the output register while new items are taken.
// VERTEX_DEPTH must be a power of two (the block does not enforce it); indices use their low bits.
`default_nettype none
module vertex_normal_accumulator_unit #(
    parameter int VERTEX_DEPTH = vnacc_pkg::DEF_VERTEX_DEPTH,
    parameter int COORD_BITS   = vnacc_pkg::DEF_COORD_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_kind,
    input  wire logic [vnacc_pkg::VTX_W-1:0]         s_vertex_a,
    input  wire logic [vnacc_pkg::VTX_W-1:0]         s_vertex_b,
    input  wire logic [vnacc_pkg::VTX_W-1:0]         s_vertex_c,
    input  wire logic signed [COORD_BITS-1:0]        s_pos_x,
    input  wire logic signed [COORD_BITS-1:0]        s_pos_y,
    input  wire logic signed [COORD_BITS-1:0]        s_pos_z,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [vnacc_pkg::ACC_W-1:0]       m_normal_x,
    output logic signed [vnacc_pkg::ACC_W-1:0]       m_normal_y,
    output logic signed [vnacc_pkg::ACC_W-1:0]       m_normal_z
);
    import vnacc_pkg::*;

    localparam int IDX_W = $clog2(VERTEX_DEPTH);
    localparam int EXT_W = IDX_W + VTX_W;
    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int CRW   = PW + 1;
    localparam int NW    = (CRW > NORM_W) ? CRW : NORM_W;
    localparam int NUMW  = NORM_W + QUO_W;
    localparam logic [NW:0] NORM_HI = (NW+1)'(1) << NORM_W;
    localparam logic [NW:0] NORM_LO = (NW+1)'(1) << (NORM_W - 1);
    localparam logic [SQR_W-1:0] SQRT_BIT0 = SQR_W'(1) << (SQR_W - 2);
    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((1 << (ACC_W - 1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -((ACC_W+1)'(1) << (ACC_W - 1));

    state_t state_reg, state_next;

    logic [EXT_W-1:0] a_ext, b_ext, c_ext;
    logic [IDX_W-1:0] a_idx, b_idx, c_idx;
    logic             accept;

    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] va_reg, vb_reg, vc_reg;
    logic [1:0]       pcnt_reg;
    logic [2:0]       ccnt_reg;
    logic [2:0]       ccm1;
    logic [1:0]       scnt_reg;
    logic [1:0]       jcnt_reg;
    logic [4:0]       dcnt_reg;
    logic [1:0]       acnt_reg;

    logic signed [CW-1:0]  pa_reg [3];
    logic signed [CW-1:0]  pb_reg [3];
    logic signed [CW-1:0]  pc_reg [3];
    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [EW-1:0]  op_a, op_b;
    logic signed [PW-1:0]  prod_reg;
    logic signed [CRW-1:0] cr_reg [3];
    logic [NW-1:0]         mag_reg [3];
    logic                  neg_reg [3];
    logic [NW-1:0]         m_reg;
    logic [NORM_W-1:0]     sq_op;
    logic [2*NORM_W-1:0]   sq_reg;
    logic [SQR_W-1:0]      sum_reg;
    logic [SQR_W-1:0]      n_reg, res_reg, bit_reg;
    logic [SQR_W-1:0]      trial;
    logic [LEN_W-1:0]      len_reg;
    logic [NUMW-1:0]       num;
    logic [LEN_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      nsh_reg, q_reg;
    logic [LEN_W+1:0]      dtrial;
    logic [UNIT_W-1:0]     qc;
    logic signed [UNIT_W-1:0] fn_reg [3];

    logic [3*CW-1:0]     pos_rdata;
    logic                pos_re;
    logic [IDX_W-1:0]    pos_raddr;
    logic                nrm_we, nrm_re;
    logic [IDX_W-1:0]    nrm_waddr, nrm_raddr;
    logic [3*ACC_W-1:0]  nrm_wdata, nrm_rdata;
    logic [3*ACC_W-1:0]  acc_sum;
    logic [IDX_W-1:0]    acc_idx;
    logic                out_load;

    assign a_ext  = EXT_W'(s_vertex_a);
    assign b_ext  = EXT_W'(s_vertex_b);
    assign c_ext  = EXT_W'(s_vertex_c);
    assign a_idx  = a_ext[IDX_W-1:0];
    assign b_idx  = b_ext[IDX_W-1:0];
    assign c_idx  = c_ext[IDX_W-1:0];
    assign accept = s_valid && s_ready;
    assign ccm1   = ccnt_reg - 3'd1;

    vnacc_ram #(.WIDTH(3 * CW), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .clk   (aclk),
        .we    (accept && s_kind == KIND_LOAD),
        .waddr (a_idx),
        .wdata ({s_pos_z, s_pos_y, s_pos_x}),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vnacc_ram #(.WIDTH(3 * ACC_W), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
        .clk   (aclk),
        .we    (nrm_we),
        .waddr (nrm_waddr),
        .wdata (nrm_wdata),
        .re    (nrm_re),
        .raddr (nrm_raddr),
        .rdata (nrm_rdata)
    );

    always_comb begin
        case (acnt_reg)
            2'd0:    acc_idx = va_reg;
            2'd1:    acc_idx = vb_reg;
            default: acc_idx = vc_reg;
        endcase
        case (pcnt_reg)
            2'd0:    pos_raddr = va_reg;
            2'd1:    pos_raddr = vb_reg;
            default: pos_raddr = vc_reg;
        endcase
        case (ccnt_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
        case (scnt_reg)
            2'd0:    sq_op = mag_reg[0][NORM_W-1:0];
            2'd1:    sq_op = mag_reg[1][NORM_W-1:0];
            default: sq_op = mag_reg[2][NORM_W-1:0];
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [ACC_W:0] s;
            s = (ACC_W+1)'($signed(nrm_rdata[i*ACC_W +: ACC_W]))
              + (ACC_W+1)'(fn_reg[i]);
            if (s > ACC_MAX) begin
                s = ACC_MAX;
            end else if (s < ACC_MIN) begin
                s = ACC_MIN;
            end
            acc_sum[i*ACC_W +: ACC_W] = s[ACC_W-1:0];
        end
    end

    assign trial  = res_reg + bit_reg;
    assign num    = NUMW'({mag_reg[jcnt_reg][NORM_W-1:0], (QUO_W-2)'(0)})
                  + NUMW'(len_reg >> 1);
    assign dtrial = {1'b0, rem_reg, nsh_reg[QUO_W-1]} - {2'b00, len_reg};
    assign qc     = (q_reg[QUO_W-1] || q_reg[QUO_W-2]) ? UNIT_W'(16'h7FFF)
                                                       : q_reg[UNIT_W-1:0];

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        pos_re     = 1'b0;
        nrm_we     = 1'b0;
        nrm_re     = 1'b0;
        nrm_waddr  = acc_idx;
        nrm_raddr  = acc_idx;
        nrm_wdata  = acc_sum;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                nrm_we    = 1'b1;
                nrm_waddr = clr_cnt_reg;
                nrm_wdata = '0;
                if (clr_cnt_reg == IDX_W'(VERTEX_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready   = 1'b1;
                nrm_raddr = a_idx;
                nrm_waddr = a_idx;
                nrm_wdata = '0;
                if (accept) begin
                    case (s_kind)
                        KIND_LOAD: nrm_we = 1'b1;
                        KIND_TRI:  state_next = ST_POS;
                        KIND_READ: begin
                            nrm_re     = 1'b1;
                            state_next = ST_RD_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_OUT: begin
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POS: begin
                pos_re = (pcnt_reg != 2'd3);
                if (pcnt_reg == 2'd3) begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:  state_next = ST_CROSS;
            ST_CROSS: begin
                if (ccnt_reg == 3'd6) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: state_next = ST_MAX;
            ST_MAX: state_next = ST_NORM;
            ST_NORM: begin
                if (m_reg == '0) begin
                    state_next = ST_IDLE;
                end else if ({1'b0, m_reg} < NORM_HI && {1'b0, m_reg} >= NORM_LO) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (scnt_reg == 2'd3) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (bit_reg == '0) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == 5'(QUO_W - 1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: state_next = (jcnt_reg == 2'd2) ? ST_ACC_RD : ST_DIV_LOAD;
            ST_ACC_RD: begin
                nrm_re     = 1'b1;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                nrm_we     = 1'b1;
                state_next = (acnt_reg == 2'd2) ? ST_IDLE : ST_ACC_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_normal_x <= nrm_rdata[0*ACC_W +: ACC_W];
            m_normal_y <= nrm_rdata[1*ACC_W +: ACC_W];
            m_normal_z <= nrm_rdata[2*ACC_W +: ACC_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= '0;
            ccnt_reg <= '0;
            scnt_reg <= '0;
            jcnt_reg <= '0;
            dcnt_reg <= '0;
            acnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        va_reg   <= a_idx;
                        vb_reg   <= b_idx;
                        vc_reg   <= c_idx;
                        pcnt_reg <= '0;
                        ccnt_reg <= '0;
                        scnt_reg <= '0;
                        jcnt_reg <= '0;
                        acnt_reg <= '0;
                    end
                end
                ST_POS: begin
                    pcnt_reg <= pcnt_reg + 2'd1;
                    for (int i = 0; i < 3; i++) begin
                        case (pcnt_reg)
                            2'd1:    pa_reg[i] <= pos_rdata[i*CW +: CW];
                            2'd2:    pb_reg[i] <= pos_rdata[i*CW +: CW];
                            2'd3:    pc_reg[i] <= pos_rdata[i*CW +: CW];
                            default: ;
                        endcase
                    end
                end
                ST_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= EW'(pb_reg[i]) - EW'(pa_reg[i]);
                        e2_reg[i] <= EW'(pc_reg[i]) - EW'(pa_reg[i]);
                    end
                end
                ST_CROSS: begin
                    ccnt_reg <= ccnt_reg + 3'd1;
                    prod_reg <= PW'(op_a) * PW'(op_b);
                    if (ccnt_reg != 3'd0) begin
                        if (!ccm1[0]) begin
                            cr_reg[ccm1[2:1]] <= CRW'(prod_reg);
                        end else begin
                            cr_reg[ccm1[2:1]] <= cr_reg[ccm1[2:1]] - CRW'(prod_reg);
                        end
                    end
                end
                ST_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        neg_reg[i] <= cr_reg[i][CRW-1];
                        mag_reg[i] <= NW'(cr_reg[i][CRW-1] ? -cr_reg[i] : cr_reg[i]);
                    end
                end
                ST_MAX: begin
                    if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2]) begin
                        m_reg <= mag_reg[0];
                    end else if (mag_reg[1] >= mag_reg[2]) begin
                        m_reg <= mag_reg[1];
                    end else begin
                        m_reg <= mag_reg[2];
                    end
                end
                ST_NORM: begin
                    sum_reg <= '0;
                    if ({1'b0, m_reg} >= NORM_HI) begin
                        m_reg <= m_reg >> 1;
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else if ({1'b0, m_reg} < NORM_LO && m_reg != '0) begin
                        m_reg <= m_reg << 1;
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end
                end
                ST_SQ: begin
                    scnt_reg <= scnt_reg + 2'd1;
                    sq_reg   <= sq_op * sq_op;
                    if (scnt_reg != 2'd0) begin
                        sum_reg <= sum_reg + SQR_W'(sq_reg);
                    end
                    n_reg   <= sum_reg + SQR_W'(sq_reg);
                    res_reg <= '0;
                    bit_reg <= SQRT_BIT0;
                end
                ST_SQRT: begin
                    if (bit_reg != '0) begin
                        if (n_reg >= trial) begin
                            n_reg   <= n_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                    len_reg <= res_reg[LEN_W-1:0];
                end
                ST_DIV_LOAD: begin
                    rem_reg  <= LEN_W'(num[NUMW-1:QUO_W]);
                    nsh_reg  <= num[QUO_W-1:0];
                    q_reg    <= '0;
                    dcnt_reg <= '0;
                end
                ST_DIV: begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                    nsh_reg  <= nsh_reg << 1;
                    if (!dtrial[LEN_W+1]) begin
                        rem_reg <= dtrial[LEN_W-1:0];
                        q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[LEN_W-2:0], nsh_reg[QUO_W-1]};
                        q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
                    end
                end
                ST_DIV_END: begin
                    fn_reg[jcnt_reg] <= neg_reg[jcnt_reg] ? -$signed(qc) : $signed(qc);
                    jcnt_reg         <= jcnt_reg + 2'd1;
                end
                ST_ACC_WR: acnt_reg <= acnt_reg + 2'd1;
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready && !nrm_re)
        else $error("item taken during normal store clearing");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> len_reg[LEN_W-1:LEN_W-2] != 2'b00 && rem_reg < len_reg)
        else $error("divider remainder or length out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NORM && state_next == ST_SQ |-> m_reg[NORM_W-1] == 1'b1)
        else $error("normalized magnitude out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("read item result lost");
endmodule
`default_nettype wire

>>> src/vnacc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module vnacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> verif/tb_vertex_normal_accumulator_unit.sv
// Testbench for vertex_normal_accumulator_unit: loads, triangles and reads, with every
// returned normal checked against a local fixed-point face normal and accumulator model.
// Depends on vnacc_pkg and the RTL of vertex_normal_accumulator_unit.
`timescale 1ns / 100ps
module tb_vertex_normal_accumulator_unit;
    import vnacc_pkg::*;

    localparam int DEPTH   = DEF_VERTEX_DEPTH;
    localparam int ACC_MAX = 8388607;
    localparam int ACC_MIN = -8388608;
    localparam kind_t KIND_NONE = 2'd3;

    typedef struct {
        kind_t             kind;
        logic [VTX_W-1:0]  va, vb, vc;
        logic signed [15:0] px, py, pz;
    } vtx_item_t;

    typedef struct {
        logic signed [ACC_W-1:0] nx, ny, nz;
    } normal_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic [VTX_W-1:0] s_vertex_a = '0, s_vertex_b = '0, s_vertex_c = '0;
    logic signed [15:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [ACC_W-1:0] m_normal_x, m_normal_y, m_normal_z;

    vertex_normal_accumulator_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_vertex_a(s_vertex_a), .s_vertex_b(s_vertex_b), .s_vertex_c(s_vertex_c),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z)
    );

    always #5 aclk = ~aclk;

    vtx_item_t pending_items[$];
    normal_t   expected_normals[$];

    logic signed [15:0] pos_mem [DEPTH][3];
    int                 acc_mem [DEPTH][3];
    bit                 loaded [DEPTH];
    int                 loaded_list[$];

    int errors = 0, n_load = 0, n_tri = 0, n_read = 0, n_none = 0, n_sat = 0;
    int n_sent = 0, n_checked = 0;

    function automatic void face_normal(input longint cx, cy, cz,
                                        output int nx, ny, nz);
        longint unsigned mg[3];
        bit ng[3];
        longint unsigned m, sum, len, bitv, rem, q;
        longint cr[3];
        int fn[3];
        int i;
        cr[0] = cx; cr[1] = cy; cr[2] = cz;
        m = 0;
        for (i = 0; i < 3; i++) begin
            ng[i] = cr[i] < 0;
            mg[i] = ng[i] ? -cr[i] : cr[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) begin
            nx = 0; ny = 0; nz = 0;
            return;
        end
        while (m >= (64'd1 << 30)) begin
            for (i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            for (i = 0; i < 3; i++) mg[i] = mg[i] << 1;
            m = m << 1;
        end
        sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        rem = sum;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem = rem - (len + bitv);
                len = (len >> 1) + bitv;
            end else begin
                len = len >> 1;
            end
            bitv = bitv >> 2;
        end
        for (i = 0; i < 3; i++) begin
            q = (mg[i] * 32768 + len / 2) / len;
            if (q > 32767) q = 32767;
            fn[i] = ng[i] ? -int'(q) : int'(q);
        end
        nx = fn[0]; ny = fn[1]; nz = fn[2];
    endfunction

    function automatic void add_normal(input int v, input int fn[3]);
        longint s;
        int i;
        for (i = 0; i < 3; i++) begin
            s = longint'(acc_mem[v][i]) + fn[i];
            if (s > ACC_MAX) s = ACC_MAX;
            if (s < ACC_MIN) s = ACC_MIN;
            acc_mem[v][i] = int'(s);
        end
    endfunction

    function automatic void predict_normals(input vtx_item_t it);
        longint e1[3], e2[3];
        int fn[3];
        int a, b, c, i;
        normal_t r;
        a = it.va; b = it.vb; c = it.vc;
        case (it.kind)
            KIND_LOAD: begin
                pos_mem[a][0] = it.px; pos_mem[a][1] = it.py; pos_mem[a][2] = it.pz;
                for (i = 0; i < 3; i++) acc_mem[a][i] = 0;
                n_load++;
            end
            KIND_TRI: begin
                for (i = 0; i < 3; i++) begin
                    e1[i] = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
                    e2[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
                end
                face_normal(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                            e1[0] * e2[1] - e1[1] * e2[0], fn[0], fn[1], fn[2]);
                add_normal(a, fn);
                add_normal(b, fn);
                add_normal(c, fn);
                n_tri++;
            end
            KIND_READ: begin
                r.nx = ACC_W'(acc_mem[a][0]);
                r.ny = ACC_W'(acc_mem[a][1]);
                r.nz = ACC_W'(acc_mem[a][2]);
                for (i = 0; i < 3; i++)
                    if (acc_mem[a][i] == ACC_MAX || acc_mem[a][i] == ACC_MIN) n_sat++;
                expected_normals.insert(expected_normals.size(), r);
                n_read++;
            end
            default: n_none++;
        endcase
    endfunction

    task automatic push_item(input kind_t k, input int a, b, c, input int x, y, z);
        vtx_item_t it;
        it.kind = k;
        it.va = VTX_W'(a); it.vb = VTX_W'(b); it.vc = VTX_W'(c);
        it.px = 16'(x); it.py = 16'(y); it.pz = 16'(z);
        pending_items.insert(pending_items.size(), it);
        if (k == KIND_LOAD && !loaded[a]) begin
            loaded[a] = 1;
            loaded_list.insert(loaded_list.size(), a);
        end
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    function automatic int rand_coord();
        return ($urandom_range(0, 1) == 0) ? $signed($urandom_range(0, 65535) - 32768)
                                           : $signed($urandom_range(0, 2047)) - 1024;
    endfunction

    // driver
    int gap = 0;
    always @(posedge aclk) begin
        vtx_item_t it;
        if (!aresetn) begin
            s_valid <= 0;
            gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                it.kind = s_kind; it.va = s_vertex_a; it.vb = s_vertex_b; it.vc = s_vertex_c;
                it.px = s_pos_x; it.py = s_pos_y; it.pz = s_pos_z;
                predict_normals(it);
                n_sent++;
            end
            if (s_valid && !s_ready) begin
            end else if (gap != 0) begin
                s_valid <= 0;
                gap <= gap - 1;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                s_kind <= it.kind;
                s_vertex_a <= it.va; s_vertex_b <= it.vb; s_vertex_c <= it.vc;
                s_pos_x <= it.px; s_pos_y <= it.py; s_pos_z <= it.pz;
                s_valid <= 1;
                gap <= ((n_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // monitor
    int stall = 0;
    always @(posedge aclk) begin
        normal_t e;
        int n;
        if (!aresetn) begin
            m_ready <= 0;
            stall <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_normals.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         m_normal_x, m_normal_y, m_normal_z);
                errors++;
            end else begin
                e = expected_normals.pop_front();
                if (m_normal_x !== e.nx) begin
                    $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, m_normal_x);
                    errors++;
                end
                if (m_normal_y !== e.ny) begin
                    $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, m_normal_y);
                    errors++;
                end
                if (m_normal_z !== e.nz) begin
                    $display("%0t: normal_z expected %0d actual %0d", $time, e.nz, m_normal_z);
                    errors++;
                end
            end
            n_checked++;
            n = ((n_checked / 20) % 3 == 1) ? 0 : $urandom_range(0, 7);
            stall <= n;
            m_ready <= (n == 0);
        end else if (stall != 0) begin
            stall <= stall - 1;
            m_ready <= (stall == 1);
        end else begin
            m_ready <= 1;
        end
    end

    initial begin
        int i, r, cnt, a;
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, degenerate, repeated corners, unused kind
        push_item(KIND_READ, 4095, 0, 0, 0, 0, 0);
        push_item(KIND_LOAD, 0, 0, 0, -32768, -32768, -32768);
        push_item(KIND_LOAD, 4095, 4095, 4095, 32767, -32768, 32767);
        push_item(KIND_LOAD, 2730, 0, 0, -32768, 32767, 32767);
        push_item(KIND_TRI, 0, 4095, 2730, 0, 0, 0);
        push_item(KIND_READ, 0, 0, 0, 0, 0, 0);
        push_item(KIND_READ, 4095, 0, 0, 0, 0, 0);
        push_item(KIND_READ, 2730, 0, 0, 0, 0, 0);
        push_item(KIND_LOAD, 1365, 0, 0, 256, 256, 256);
        push_item(KIND_LOAD, 1366, 0, 0, 512, 512, 512);
        push_item(KIND_LOAD, 1367, 0, 0, 0, 0, 0);
        push_item(KIND_TRI, 1367, 1365, 1366, 0, 0, 0);
        push_item(KIND_TRI, 0, 0, 4095, 0, 0, 0);
        push_item(KIND_TRI, 2730, 2730, 2730, 0, 0, 0);
        push_item(KIND_LOAD, 100, 0, 0, 0, 0, 0);
        push_item(KIND_LOAD, 101, 0, 0, 1, 0, 0);
        push_item(KIND_LOAD, 102, 0, 0, 0, 1, 0);
        push_item(KIND_TRI, 100, 101, 102, 0, 0, 0);
        push_item(KIND_NONE, 4095, 4095, 4095, -1, -1, -1);
        push_item(KIND_READ, 100, 4095, 4095, -1, -1, -1);
        push_item(KIND_READ, 1367, 0, 0, 0, 0, 0);
        push_item(KIND_LOAD, 0, 0, 0, 1, 2, 3);
        push_item(KIND_READ, 0, 0, 0, 0, 0, 0);

        // random mix
        cnt = 0;
        while (cnt < 50) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                push_item(KIND_LOAD, $urandom_range(0, DEPTH - 1), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord());
                cnt++;
            end else if (r < 65) begin
                push_item(KIND_TRI, any_loaded(), any_loaded(), any_loaded(),
                          rand_coord(), rand_coord(), rand_coord());
                cnt++;
            end else if (r < 90) begin
                a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH - 1) : any_loaded();
                push_item(KIND_READ, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          rand_coord(), rand_coord(), rand_coord());
                cnt++;
            end else if (r < 94) begin
                push_item(KIND_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord());
            end else begin
                a = any_loaded();
                push_item(KIND_TRI, a, a, any_loaded(), 0, 0, 0);
                cnt++;
            end
        end

        // drive accumulators into saturation, x upward and y downward
        push_item(KIND_LOAD, 4000, 0, 0, 0, 0, 0);
        push_item(KIND_LOAD, 4001, 0, 0, 256, 256, 0);
        push_item(KIND_LOAD, 4002, 0, 0, 0, 0, 256);
        for (i = 0; i < 365; i++) begin
            push_item(KIND_TRI, 4000, 4001, 4002, 0, 0, 0);
            if (i % 96 == 0) push_item(KIND_READ, 4000, 0, 0, 0, 0, 0);
        end
        push_item(KIND_READ, 4000, 0, 0, 0, 0, 0);
        push_item(KIND_READ, 4001, 0, 0, 0, 0, 0);
        push_item(KIND_READ, 4002, 0, 0, 0, 0, 0);

        while (pending_items.size() != 0 || s_valid || expected_normals.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d loads, %0d triangles, %0d reads, %0d unused-kind items;",
                 n_load, n_tri, n_read, n_none);
        $display("%0d saturated components read back, %0d checks failed.", n_sat, errors);
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end
endmodule
